// ----- src/rft_pkg.sv -----
// Shared constants, CORDIC payload type and step-angle table for the rectangle fit test.
package rft_pkg;

    // Sides are placed at bit SCALE_TOTAL - side width, so every scaled side is 58 bits wide.
    localparam int SCALE_TOTAL = 58;
    // Root digits: the radicand is always 118 bits wide (two bits per step).
    localparam int SQRT_STEPS  = 59;
    localparam int ROOT_W      = 59;
    localparam int REM_W       = 61;
    // CORDIC datapath: the scaled vector grows to just above 2^59.
    localparam int XY_W        = 64;
    localparam int Z_W         = 20;
    // Angles in units of 2^-16 of a right angle.
    localparam int ANG_W       = 17;
    localparam int NEED_W      = 19;
    localparam int RIGHT_ANGLE = 65536;
    localparam int MAX_STEPS   = 32;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   y_zero;
        logic                   x_zero;
    } t_cordic;

    // atan(2^-i), rounded to the nearest angle unit
    function automatic logic signed [Z_W-1:0] step_angle(input int i);
        logic signed [Z_W-1:0] a;
        case (i)
            0:       a = Z_W'(32768);
            1:       a = Z_W'(19344);
            2:       a = Z_W'(10221);
            3:       a = Z_W'(5188);
            4:       a = Z_W'(2604);
            5:       a = Z_W'(1303);
            6:       a = Z_W'(652);
            7:       a = Z_W'(326);
            8:       a = Z_W'(163);
            9:       a = Z_W'(81);
            10:      a = Z_W'(41);
            11:      a = Z_W'(20);
            12:      a = Z_W'(10);
            13:      a = Z_W'(5);
            14:      a = Z_W'(3);
            15:      a = Z_W'(1);
            16:      a = Z_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- src/rectangle_fit_test_top.sv -----
// Rectangle fit test: pipeline of root-digit cells and CORDIC cells, one query per cycle
//   while o_stall is low; 4 front stages, 59 root-digit cells, CORDIC_STEPS rotation cells,
//   angle and output regs.
// The 59-cell root chain and the CORDIC rows set the depth.
// A two-entry output (register plus skid): under i_stall the pipe runs until the skid fills.
// Reset (synchronous, active low) clears all valid flags; no clearing pass is needed.
module rectangle_fit_test_top #(
    parameter int SIDE_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_first_width,
    input  logic [15:0] i_first_height,
    input  logic [15:0] i_second_width,
    input  logic [15:0] i_second_height,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_fits
);

    localparam int SCALE = rft_pkg::SCALE_TOTAL - SIDE_BITS;
    localparam int SQ_W  = 2 * SIDE_BITS;
    localparam int DG_W  = 2 * SIDE_BITS + 1;
    localparam int RAD_W = 2 * SIDE_BITS + 2;
    localparam int XY_W  = rft_pkg::XY_W;
    localparam int ANG_W = rft_pkg::ANG_W;
    localparam int NEED_W = rft_pkg::NEED_W;
    localparam int SQN   = rft_pkg::SQRT_STEPS;

    typedef struct packed {
        logic valid;
        logic axis0;   // second inside first is axis-aligned
        logic ok0;     // second inside first still possible by rotation
        logic axis1;
        logic ok1;
    } t_flags;

    typedef struct packed {
        t_flags                flg;
        logic [SIDE_BITS-1:0]  a;
        logic [SIDE_BITS-1:0]  b;
        logic [SIDE_BITS-1:0]  c;
        logic [SIDE_BITS-1:0]  d;
    } t_ctx;

    // place a side at the common fixed-point scale
    function automatic logic signed [XY_W-1:0] scaled(input logic [SIDE_BITS-1:0] s);
        return signed'(XY_W'(s) << SCALE);
    endfunction

    function automatic rft_pkg::t_cordic vec_in(input logic signed [XY_W-1:0] y,
                                                input logic signed [XY_W-1:0] x);
        rft_pkg::t_cordic v;
        v.x      = x;
        v.y      = y;
        v.z      = '0;
        v.y_zero = (y == '0);
        v.x_zero = (x == '0);
        return v;
    endfunction

    logic r_out_valid, r_out_fits;
    logic r_skid_valid, r_skid_fits;

    // Pipe advances as long as the skid entry is free.
    logic en;
    assign en = !r_skid_valid;

    // ---------------- stage 0: mask and sort each side pair ----------------
    logic [SIDE_BITS-1:0] fw, fh, sw, sh;
    logic [SIDE_BITS-1:0] n_s0_a, n_s0_b, n_s0_c, n_s0_d;
    logic                 r_s0_valid;
    logic [SIDE_BITS-1:0] r_s0_a, r_s0_b, r_s0_c, r_s0_d;

    always_comb begin
        fw = SIDE_BITS'(i_first_width);
        fh = SIDE_BITS'(i_first_height);
        sw = SIDE_BITS'(i_second_width);
        sh = SIDE_BITS'(i_second_height);
        // shorter side first
        n_s0_a = (fw > fh) ? fh : fw;
        n_s0_b = (fw > fh) ? fw : fh;
        n_s0_c = (sw > sh) ? sh : sw;
        n_s0_d = (sw > sh) ? sw : sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_a <= n_s0_a;
            r_s0_b <= n_s0_b;
            r_s0_c <= n_s0_c;
            r_s0_d <= n_s0_d;
        end
    end

    // ---------------- stage 1: squares and axis-aligned checks ----------------
    logic                 r_s1_valid;
    logic [SIDE_BITS-1:0] r_s1_a, r_s1_b, r_s1_c, r_s1_d;
    logic [SQ_W-1:0]      r_s1_sq_a, r_s1_sq_b, r_s1_sq_c, r_s1_sq_d;
    logic                 r_s1_axis0, r_s1_both0, r_s1_axis1, r_s1_both1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_a     <= r_s0_a;
            r_s1_b     <= r_s0_b;
            r_s1_c     <= r_s0_c;
            r_s1_d     <= r_s0_d;
            r_s1_sq_a  <= SQ_W'(r_s0_a) * SQ_W'(r_s0_a);
            r_s1_sq_b  <= SQ_W'(r_s0_b) * SQ_W'(r_s0_b);
            r_s1_sq_c  <= SQ_W'(r_s0_c) * SQ_W'(r_s0_c);
            r_s1_sq_d  <= SQ_W'(r_s0_d) * SQ_W'(r_s0_d);
            // direction 0: first (a, b) is the outer box, second (c, d) the inner
            r_s1_axis0 <= (r_s0_a >= r_s0_c) && (r_s0_b >= r_s0_d);
            r_s1_both0 <= (r_s0_a <  r_s0_c) && (r_s0_b <  r_s0_d);
            // direction 1: second is outer, first is inner
            r_s1_axis1 <= (r_s0_c >= r_s0_a) && (r_s0_d >= r_s0_b);
            r_s1_both1 <= (r_s0_c <  r_s0_a) && (r_s0_d <  r_s0_b);
        end
    end

    // ---------------- stage 2: squared diagonals ----------------
    logic                 r_s2_valid;
    logic [SIDE_BITS-1:0] r_s2_a, r_s2_b, r_s2_c, r_s2_d;
    logic [SQ_W-1:0]      r_s2_sq_a, r_s2_sq_b, r_s2_sq_c, r_s2_sq_d;
    logic [DG_W-1:0]      r_s2_dg_ab, r_s2_dg_cd;
    logic                 r_s2_axis0, r_s2_both0, r_s2_axis1, r_s2_both1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_a     <= r_s1_a;
            r_s2_b     <= r_s1_b;
            r_s2_c     <= r_s1_c;
            r_s2_d     <= r_s1_d;
            r_s2_sq_a  <= r_s1_sq_a;
            r_s2_sq_b  <= r_s1_sq_b;
            r_s2_sq_c  <= r_s1_sq_c;
            r_s2_sq_d  <= r_s1_sq_d;
            r_s2_dg_ab <= DG_W'(r_s1_sq_a) + DG_W'(r_s1_sq_b);
            r_s2_dg_cd <= DG_W'(r_s1_sq_c) + DG_W'(r_s1_sq_d);
            r_s2_axis0 <= r_s1_axis0;
            r_s2_both0 <= r_s1_both0;
            r_s2_axis1 <= r_s1_axis1;
            r_s2_both1 <= r_s1_both1;
        end
    end

    // ---------------- stage 3: root radicands and diagonal checks ----------------
    // An outer side at least as long as the inner diagonal cuts no arc: its radicand
    // is forced to zero, which makes the root zero and the CORDIC angle zero.
    t_ctx             n_s3_ctx, r_s3_ctx;
    logic [RAD_W-1:0] n_rad_a, n_rad_b, n_rad_c, n_rad_d;
    logic [RAD_W-1:0] r_rad_a, r_rad_b, r_rad_c, r_rad_d;

    always_comb begin
        n_s3_ctx.flg.valid = r_s2_valid;
        n_s3_ctx.flg.axis0 = r_s2_axis0;
        n_s3_ctx.flg.ok0   = !r_s2_both0 && !(r_s2_dg_ab < r_s2_dg_cd);
        n_s3_ctx.flg.axis1 = r_s2_axis1;
        n_s3_ctx.flg.ok1   = !r_s2_both1 && !(r_s2_dg_cd < r_s2_dg_ab);
        n_s3_ctx.a         = r_s2_a;
        n_s3_ctx.b         = r_s2_b;
        n_s3_ctx.c         = r_s2_c;
        n_s3_ctx.d         = r_s2_d;
        n_rad_a = (DG_W'(r_s2_sq_a) < r_s2_dg_cd) ?
                  RAD_W'(r_s2_dg_cd - DG_W'(r_s2_sq_a)) : '0;
        n_rad_b = (DG_W'(r_s2_sq_b) < r_s2_dg_cd) ?
                  RAD_W'(r_s2_dg_cd - DG_W'(r_s2_sq_b)) : '0;
        n_rad_c = (DG_W'(r_s2_sq_c) < r_s2_dg_ab) ?
                  RAD_W'(r_s2_dg_ab - DG_W'(r_s2_sq_c)) : '0;
        n_rad_d = (DG_W'(r_s2_sq_d) < r_s2_dg_ab) ?
                  RAD_W'(r_s2_dg_ab - DG_W'(r_s2_sq_d)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctx.flg.valid <= 1'b0;
        end else if (en) begin
            r_s3_ctx <= n_s3_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad_a <= n_rad_a;
            r_rad_b <= n_rad_b;
            r_rad_c <= n_rad_c;
            r_rad_d <= n_rad_d;
        end
    end

    // ---------------- root chains, with the query context riding alongside ----------------
    logic [rft_pkg::ROOT_W-1:0] root_a, root_b, root_c, root_d;
    t_ctx                       r_ctx [0:SQN-1];

    rft_sqrt_chain #(.RAD_W(RAD_W)) u_sqrt_a (
        .i_clk(i_clk), .i_en(en), .i_rad(r_rad_a), .o_root(root_a));
    rft_sqrt_chain #(.RAD_W(RAD_W)) u_sqrt_b (
        .i_clk(i_clk), .i_en(en), .i_rad(r_rad_b), .o_root(root_b));
    rft_sqrt_chain #(.RAD_W(RAD_W)) u_sqrt_c (
        .i_clk(i_clk), .i_en(en), .i_rad(r_rad_c), .o_root(root_c));
    rft_sqrt_chain #(.RAD_W(RAD_W)) u_sqrt_d (
        .i_clk(i_clk), .i_en(en), .i_rad(r_rad_d), .o_root(root_d));

    for (genvar k = 0; k < SQN; k++) begin : g_ctx
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctx[k].flg.valid <= 1'b0;
            end else if (en) begin
                r_ctx[k] <= (k == 0) ? r_s3_ctx : r_ctx[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ---------------- CORDIC rows: three angles per direction ----------------
    t_ctx             ctx_end;
    rft_pkg::t_cordic cd_a, cd_b, cd_c, cd_d, cd_n0, cd_n1;
    logic [ANG_W-1:0] ang_a, ang_b, ang_c, ang_d, ang_n0, ang_n1;
    t_flags           r_flg [0:CORDIC_STEPS-1];

    always_comb begin
        ctx_end = r_ctx[SQN-1];
        // arcs cut off by each outer side on the inner diagonal circle
        cd_a  = vec_in(signed'(XY_W'(root_a)), scaled(ctx_end.a));
        cd_b  = vec_in(signed'(XY_W'(root_b)), scaled(ctx_end.b));
        cd_c  = vec_in(signed'(XY_W'(root_c)), scaled(ctx_end.c));
        cd_d  = vec_in(signed'(XY_W'(root_d)), scaled(ctx_end.d));
        // half arc spanned by the inner box corners
        cd_n0 = vec_in(scaled(ctx_end.c), scaled(ctx_end.d));
        cd_n1 = vec_in(scaled(ctx_end.a), scaled(ctx_end.b));
    end

    rft_cordic_chain #(.STEPS(CORDIC_STEPS)) u_cd_a (
        .i_clk(i_clk), .i_en(en), .i_d(cd_a), .o_angle(ang_a));
    rft_cordic_chain #(.STEPS(CORDIC_STEPS)) u_cd_b (
        .i_clk(i_clk), .i_en(en), .i_d(cd_b), .o_angle(ang_b));
    rft_cordic_chain #(.STEPS(CORDIC_STEPS)) u_cd_c (
        .i_clk(i_clk), .i_en(en), .i_d(cd_c), .o_angle(ang_c));
    rft_cordic_chain #(.STEPS(CORDIC_STEPS)) u_cd_d (
        .i_clk(i_clk), .i_en(en), .i_d(cd_d), .o_angle(ang_d));
    rft_cordic_chain #(.STEPS(CORDIC_STEPS)) u_cd_n0 (
        .i_clk(i_clk), .i_en(en), .i_d(cd_n0), .o_angle(ang_n0));
    rft_cordic_chain #(.STEPS(CORDIC_STEPS)) u_cd_n1 (
        .i_clk(i_clk), .i_en(en), .i_d(cd_n1), .o_angle(ang_n1));

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_flg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_flg[k].valid <= 1'b0;
            end else if (en) begin
                r_flg[k] <= (k == 0) ? ctx_end.flg : r_flg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ---------------- final stage: register angles, then sum and compare ----------------
    t_flags            r_fin;
    logic [ANG_W-1:0]  r_ang_a, r_ang_b, r_ang_c, r_ang_d, r_ang_n0, r_ang_n1;
    logic [NEED_W-1:0] need0, need1;
    logic              fit0, fit1, last_valid, last_fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin.valid <= 1'b0;
        end else if (en) begin
            r_fin <= r_flg[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang_a  <= ang_a;
            r_ang_b  <= ang_b;
            r_ang_c  <= ang_c;
            r_ang_d  <= ang_d;
            r_ang_n0 <= ang_n0;
            r_ang_n1 <= ang_n1;
        end
    end

    always_comb begin
        need0 = (NEED_W'(r_ang_n0) << 1) + NEED_W'(r_ang_a) + NEED_W'(r_ang_b);
        need1 = (NEED_W'(r_ang_n1) << 1) + NEED_W'(r_ang_c) + NEED_W'(r_ang_d);
        fit0  = r_fin.axis0 || (r_fin.ok0 && (need0 <= NEED_W'(rft_pkg::RIGHT_ANGLE)));
        fit1  = r_fin.axis1 || (r_fin.ok1 && (need1 <= NEED_W'(rft_pkg::RIGHT_ANGLE)));
        last_valid = r_fin.valid;
        last_fits  = fit0 || fit1;
    end

    // ---------------- output register plus skid entry ----------------
    // The pipe keeps moving while the skid entry is empty, so a result that finishes
    // while the output is stalled lands in the skid; then hold the whole pipe.
    logic out_take;

    assign out_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_fits   <= r_skid_fits;
                r_skid_valid <= 1'b0;
            end
        end else if (last_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
                r_out_fits  <= last_fits;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_fits  <= last_fits;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_fits  = r_out_fits;
    assign o_stall = r_skid_valid;

    // ---------------- checks ----------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall raised without a stalled output");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_stall) |=> $stable(r_fin) && $stable(r_ang_n0))
        else $error("pipeline advanced while frozen");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> !r_skid_valid && r_out_valid)
        else $error("skid entry not moved to the output after a transfer");

endmodule

// ----- src/rft_sqrt_cell.sv -----
// One digit step of the integer square root: two radicand bits in, one root bit out.
module rft_sqrt_cell #(
    parameter int RAD_W = 34
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [RAD_W-1:0]           i_rad,
    input  logic [rft_pkg::REM_W-1:0]  i_rem,
    input  logic [rft_pkg::ROOT_W-1:0] i_root,
    output logic [RAD_W-1:0]           o_rad,
    output logic [rft_pkg::REM_W-1:0]  o_rem,
    output logic [rft_pkg::ROOT_W-1:0] o_root
);

    localparam int TW = rft_pkg::REM_W + 2;

    logic [TW-1:0]                trial;
    logic [TW-1:0]                test;
    logic                         ge;
    logic [RAD_W-1:0]             r_rad, n_rad;
    logic [rft_pkg::REM_W-1:0]    r_rem, n_rem;
    logic [rft_pkg::ROOT_W-1:0]   r_root, n_root;

    always_comb begin
        trial  = {i_rem, i_rad[RAD_W-1 -: 2]};
        test   = TW'({i_root, 2'b01});
        ge     = (trial >= test);
        n_rem  = ge ? rft_pkg::REM_W'(trial - test) : rft_pkg::REM_W'(trial);
        n_root = {i_root[rft_pkg::ROOT_W-2:0], ge};
        n_rad  = {i_rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ----- src/rft_sqrt_chain.sv -----
// Row of root-digit cells giving floor(sqrt(radicand * 2^(2*scale))).
module rft_sqrt_chain #(
    parameter int RAD_W = 34
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [RAD_W-1:0]           i_rad,
    output logic [rft_pkg::ROOT_W-1:0] o_root
);

    localparam int N = rft_pkg::SQRT_STEPS;

    logic [RAD_W-1:0]           w_rad  [0:N];
    logic [rft_pkg::REM_W-1:0]  w_rem  [0:N];
    logic [rft_pkg::ROOT_W-1:0] w_root [0:N];

    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        rft_sqrt_cell #(.RAD_W(RAD_W)) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_rad  (w_rad[k]),
            .i_rem  (w_rem[k]),
            .i_root (w_root[k]),
            .o_rad  (w_rad[k+1]),
            .o_rem  (w_rem[k+1]),
            .o_root (w_root[k+1])
        );
    end

    assign o_root = w_root[N];

endmodule

// ----- src/rft_cordic_cell.sv -----
// One vectoring CORDIC rotation with a fixed shift and step angle.
module rft_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  rft_pkg::t_cordic i_d,
    output rft_pkg::t_cordic o_d
);

    localparam logic signed [rft_pkg::Z_W-1:0] ANG = rft_pkg::step_angle(STEP);

    logic signed [rft_pkg::XY_W-1:0] dx;
    logic signed [rft_pkg::XY_W-1:0] dy;
    rft_pkg::t_cordic                r_d, n_d;

    always_comb begin
        dx  = $signed(i_d.y) >>> STEP;
        dy  = $signed(i_d.x) >>> STEP;
        n_d = i_d;
        if (!i_d.y[rft_pkg::XY_W-1]) begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + ANG;
        end else begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ----- src/rft_cordic_chain.sv -----
// Row of CORDIC cells; the final angle is clamped to zero .. one right angle.
module rft_cordic_chain #(
    parameter int STEPS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  rft_pkg::t_cordic          i_d,
    output logic [rft_pkg::ANG_W-1:0] o_angle
);

    localparam logic signed [rft_pkg::Z_W-1:0] Z_RIGHT = rft_pkg::Z_W'(rft_pkg::RIGHT_ANGLE);

    rft_pkg::t_cordic w_d [0:STEPS];

    assign w_d[0] = i_d;

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        rft_cordic_cell #(.STEP(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_d[k]),
            .o_d   (w_d[k+1])
        );
    end

    always_comb begin
        if (w_d[STEPS].y_zero) begin
            o_angle = '0;
        end else if (w_d[STEPS].x_zero) begin
            o_angle = rft_pkg::ANG_W'(rft_pkg::RIGHT_ANGLE);
        end else if (w_d[STEPS].z[rft_pkg::Z_W-1]) begin
            o_angle = '0;
        end else if ($signed(w_d[STEPS].z) > Z_RIGHT) begin
            o_angle = rft_pkg::ANG_W'(rft_pkg::RIGHT_ANGLE);
        end else begin
            o_angle = rft_pkg::ANG_W'(w_d[STEPS].z);
        end
    end

endmodule

// ----- tb/rectangle_fit_test_top_tb.sv -----
// Self-checking testbench for the rectangle fit test pipeline.
module rectangle_fit_test_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCALE_SH   = 58 - 16;
    localparam int LATENCY    = 16 + 65;
    localparam int N_RANDOM   = 2000;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 400;

    // A query: four sides, plus an optional typed-in verdict.
    typedef struct {
        logic [15:0] fw, fh, sw, sh;
        bit          known;
        bit          verdict;
    } t_query;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_first_width = '0;
    logic [15:0] i_first_height = '0;
    logic [15:0] i_second_width = '0;
    logic [15:0] i_second_height = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_fits;

    t_query query_q[$];
    bit     pending_fits[$];
    int     err_count = 0;
    int     sent = 0;
    bit     rst_done = 1'b0;

    rectangle_fit_test_top dut (.*);

    always #5 i_clk = ~i_clk;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // Floor integer root, bit-by-bit search over 64 root bits.
    function automatic longint unsigned root_floor(input logic [127:0] v);
        longint unsigned r;
        logic [127:0]    c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = {64'd0, r | (64'd1 << b)};
            if (!(v < c * c)) r = r | (64'd1 << b);
        end
        return r;
    endfunction

    // Vectoring CORDIC, result in 2^-16 of a right angle, clamped.
    function automatic longint arc_of(input longint y0, input longint x0);
        longint x, y, z, dx, dy;
        x = x0;
        y = y0;
        z = 0;
        if (y == 0) return 0;
        if (x == 0) return rft_pkg::RIGHT_ANGLE;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + longint'(rft_pkg::step_angle(i));
            end else begin
                x = x - dx; y = y + dy; z = z - longint'(rft_pkg::step_angle(i));
            end
        end
        if (z < 0) z = 0;
        if (z > rft_pkg::RIGHT_ANGLE) z = rft_pkg::RIGHT_ANGLE;
        return z;
    endfunction

    // Arc that outer side s cuts off the circle of squared radius diag.
    function automatic longint cut_arc(input longint unsigned s, input logic [127:0] diag);
        logic [127:0]    sq;
        longint unsigned r;
        sq = {64'd0, s} * {64'd0, s};
        if (!(sq < diag)) return 0;
        r = root_floor((diag - sq) << (2 * SCALE_SH));
        return arc_of(longint'(r), longint'(s << SCALE_SH));
    endfunction

    // Outer p <= q, inner u <= v.
    function automatic bit fits_inside(input longint unsigned p, q, u, v);
        logic [127:0] od, id;
        longint       need;
        if (p >= u && q >= v) return 1'b1;
        if (p < u && q < v) return 1'b0;
        od = {64'd0, p} * {64'd0, p} + {64'd0, q} * {64'd0, q};
        id = {64'd0, u} * {64'd0, u} + {64'd0, v} * {64'd0, v};
        if (od < id) return 1'b0;
        need = 2 * arc_of(longint'(u << SCALE_SH), longint'(v << SCALE_SH));
        need = need + cut_arc(p, id) + cut_arc(q, id);
        return need <= rft_pkg::RIGHT_ANGLE;
    endfunction

    function automatic bit fit_verdict(input t_query qr);
        longint unsigned a, b, c, d;
        a = qr.fw; b = qr.fh; c = qr.sw; d = qr.sh;
        if (a > b) begin a = qr.fh; b = qr.fw; end
        if (c > d) begin c = qr.sh; d = qr.sw; end
        return fits_inside(a, b, c, d) || fits_inside(c, d, a, b);
    endfunction

    function automatic t_query mk(input int a, b, c, d, input bit k = 0, input bit v = 0);
        t_query qr;
        qr.fw = a[15:0]; qr.fh = b[15:0]; qr.sw = c[15:0]; qr.sh = d[15:0];
        qr.known = k;
        qr.verdict = v;
        return qr;
    endfunction

    // Random query: full range, near-tilted fit, or tiny sides.
    function automatic t_query rand_query();
        int p, q, u, v, sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            return mk($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
        end else if (sel < 8) begin
            // inner box slightly longer than the outer box, much thinner
            p = $urandom_range(1, 65535);
            q = $urandom_range(p, 65535);
            u = $urandom_range(0, p - 1);
            v = q + $urandom_range(1, q / 4 + 1);
            if (v > 65535) v = 65535;
            if ($urandom_range(0, 1)) return mk(p, q, v, u);
            return mk(u, v, q, p);
        end
        return mk($urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom_range(0, 15));
    endfunction

    // Sender: bursts of random length with random gaps; hold payload while stalled.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        bit taken;
        if (rst_done) begin
            taken = i_valid && !o_stall;
            if (taken) begin
                pending_fits.push_back(query_q[0].known ? query_q[0].verdict
                                                        : fit_verdict(query_q[0]));
                void'(query_q.pop_front());
                sent++;
            end
            if (!(i_valid && !taken)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (query_q.size() > 0) begin
                    i_valid <= 1'b1;
                    i_first_width <= query_q[0].fw;
                    i_first_height <= query_q[0].fh;
                    i_second_width <= query_q[0].sw;
                    i_second_height <= query_q[0].sh;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        // new burst; zero gap keeps stretches of back-to-back transfers
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern redrawn at random among four modes; one long hold-off
    // once enough transfers went in, so the pipe fills and stalls its input.
    int cyc = 0;
    int mode = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        cyc++;
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        if (!hold_done && sent >= HOLD_AT) begin
            hold_cnt++;
            if (hold_cnt >= HOLD_LEN) hold_done = 1'b1;
            i_stall <= 1'b1;
        end else begin
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 9) < 3);
                2: i_stall <= cyc[0];
                default: i_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Checker: compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (rst_done && o_valid && !i_stall) begin
            if (pending_fits.size() == 0) begin
                report($sformatf("result %0b with nothing expected", o_fits));
            end else begin
                if (o_fits !== pending_fits[0])
                    report($sformatf("fits %0b, expected %0b", o_fits, pending_fits[0]));
                void'(pending_fits.pop_front());
            end
        end
    end

    initial begin
        // directed rows: typed-in verdicts only where obvious
        query_q.push_back(mk(0, 0, 0, 0, 1, 1));
        query_q.push_back(mk(65535, 65535, 65535, 65535, 1, 1));
        query_q.push_back(mk(0, 0, 65535, 65535, 1, 1));
        query_q.push_back(mk(65535, 65535, 65535, 65534, 1, 1));
        query_q.push_back(mk(5, 5, 6, 6, 1, 1));
        query_q.push_back(mk(7, 3, 4, 8, 1, 1));
        query_q.push_back(mk(1, 65535, 65535, 1, 1, 1));
        query_q.push_back(mk(2, 65535, 3, 65534));
        query_q.push_back(mk(2, 2, 1, 3));
        query_q.push_back(mk(4, 8, 3, 9));
        query_q.push_back(mk(0, 5, 3, 3));
        query_q.push_back(mk(0, 65535, 1, 100));
        query_q.push_back(mk(80, 80, 1, 100));
        query_q.push_back(mk(1, 112, 80, 80));
        query_q.push_back(mk(65535, 0, 65535, 0, 1, 1));
        query_q.push_back(mk(100, 1000, 10, 1003));
        query_q.push_back(mk(100, 1000, 10, 1005));
        query_q.push_back(mk(50000, 50000, 1, 65535));
        query_q.push_back(mk(43690, 21845, 21845, 43690, 1, 1));
        query_q.push_back(mk(32768, 32767, 1, 45000));
        for (int i = 0; i < N_RANDOM; i++) query_q.push_back(rand_query());

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        // drain: all transfers in, all results out, then sit out the latency
        wait (query_q.size() == 0 && pending_fits.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (pending_fits.size() != 0) report("expected results left over");
        if (err_count == 0) begin
            $display("rectangle_fit_test_top regression: pass");
        end else begin
            $display("rectangle_fit_test_top regression: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("rectangle_fit_test_top regression: fail");
        $finish;
    end

endmodule

// ----- rectangle_fit_test_top.f -----
src/rft_pkg.sv
src/rft_sqrt_cell.sv
src/rft_sqrt_chain.sv
src/rft_cordic_cell.sv
src/rft_cordic_chain.sv
src/rectangle_fit_test_top.sv
tb/rectangle_fit_test_top_tb.sv
